/* rtl/core/mrfs_pkg.sv */
package mrfs_pkg;

  localparam int CNT_W    = 16;
  localparam int SUM_W    = 32;
  localparam int SMP_W    = 16;
  localparam int NUM_DIV  = 6;
  localparam int NUM_AXES = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FRAME_PERIOD = 3'd0;
  localparam logic [2:0] REG_FAST_DIV     = 3'd1;
  localparam logic [2:0] REG_SLOW_DIV     = 3'd2;
  localparam logic [2:0] REG_MID_DIV      = 3'd3;
  localparam logic [2:0] REG_MAG_DIV      = 3'd4;
  localparam logic [2:0] REG_LOW_DIV      = 3'd5;
  localparam logic [2:0] REG_SECOND_DIV   = 3'd6;

  // Divisor slots, also the bit positions in rate_pulses.
  localparam int DIV_FAST   = 0;
  localparam int DIV_SLOW   = 1;
  localparam int DIV_MID    = 2;
  localparam int DIV_MAG    = 3;
  localparam int DIV_LOW    = 4;
  localparam int DIV_SECOND = 5;

  localparam logic [CNT_W-1:0] RST_FRAME_PERIOD = 16'd1000;
  localparam logic [CNT_W-1:0] RST_FAST_DIV     = 16'd2;
  localparam logic [CNT_W-1:0] RST_SLOW_DIV     = 16'd10;
  localparam logic [CNT_W-1:0] RST_MID_DIV      = 16'd20;
  localparam logic [CNT_W-1:0] RST_MAG_DIV      = 16'd100;
  localparam logic [CNT_W-1:0] RST_LOW_DIV      = 16'd200;
  localparam logic [CNT_W-1:0] RST_SECOND_DIV   = 16'd1000;

  typedef logic [NUM_DIV-1:0][CNT_W-1:0] div_vec_t;

  typedef struct packed {
    logic                    system_ready;
    logic                    console_busy;
    logic                    accel_cal_active;
    logic                    esc_cal_active;
    logic                    gyro_cal_active;
    logic                    mag_cal_active;
    logic signed [SMP_W-1:0] accel_x;
    logic signed [SMP_W-1:0] accel_y;
    logic signed [SMP_W-1:0] accel_z;
    logic signed [SMP_W-1:0] gyro_roll;
    logic signed [SMP_W-1:0] gyro_pitch;
    logic signed [SMP_W-1:0] gyro_yaw;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]        uptime_ms;
    logic [NUM_DIV-1:0]      rate_pulses;
    logic                    mag_read_request;
    logic signed [SUM_W-1:0] fast_accel_sum_x;
    logic signed [SUM_W-1:0] fast_accel_sum_y;
    logic signed [SUM_W-1:0] fast_accel_sum_z;
    logic signed [SUM_W-1:0] fast_gyro_sum_roll;
    logic signed [SUM_W-1:0] fast_gyro_sum_pitch;
    logic signed [SUM_W-1:0] fast_gyro_sum_yaw;
    logic signed [SUM_W-1:0] slow_accel_sum_x;
    logic signed [SUM_W-1:0] slow_accel_sum_y;
    logic signed [SUM_W-1:0] slow_accel_sum_z;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] frame_period;
    div_vec_t         divs;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

/* rtl/core/mrfs_regs.sv */
module mrfs_regs
  import mrfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              cfg_wr
);

  logic [CNT_W-1:0] period_r;
  div_vec_t         divs_r;
  logic [2:0]       idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_wr = wr_en;

  assign cfg.frame_period = period_r;
  assign cfg.divs         = divs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r             <= RST_FRAME_PERIOD;
      divs_r[DIV_FAST]     <= RST_FAST_DIV;
      divs_r[DIV_SLOW]     <= RST_SLOW_DIV;
      divs_r[DIV_MID]      <= RST_MID_DIV;
      divs_r[DIV_MAG]      <= RST_MAG_DIV;
      divs_r[DIV_LOW]      <= RST_LOW_DIV;
      divs_r[DIV_SECOND]   <= RST_SECOND_DIV;
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_PERIOD: period_r           <= pwdata[CNT_W-1:0];
        REG_FAST_DIV:     divs_r[DIV_FAST]   <= pwdata[CNT_W-1:0];
        REG_SLOW_DIV:     divs_r[DIV_SLOW]   <= pwdata[CNT_W-1:0];
        REG_MID_DIV:      divs_r[DIV_MID]    <= pwdata[CNT_W-1:0];
        REG_MAG_DIV:      divs_r[DIV_MAG]    <= pwdata[CNT_W-1:0];
        REG_LOW_DIV:      divs_r[DIV_LOW]    <= pwdata[CNT_W-1:0];
        REG_SECOND_DIV:   divs_r[DIV_SECOND] <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FRAME_PERIOD: prdata = DATA_W'(period_r);
      REG_FAST_DIV:     prdata = DATA_W'(divs_r[DIV_FAST]);
      REG_SLOW_DIV:     prdata = DATA_W'(divs_r[DIV_SLOW]);
      REG_MID_DIV:      prdata = DATA_W'(divs_r[DIV_MID]);
      REG_MAG_DIV:      prdata = DATA_W'(divs_r[DIV_MAG]);
      REG_LOW_DIV:      prdata = DATA_W'(divs_r[DIV_LOW]);
      REG_SECOND_DIV:   prdata = DATA_W'(divs_r[DIV_SECOND]);
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/core/mrfs_remdiv.sv */
module mrfs_remdiv
  import mrfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] frame_i,
  input  div_vec_t         divs,
  output div_vec_t         rems,
  output rem_stat_t        stat
);

  localparam int STEP_W = $clog2(CNT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  div_vec_t          rem_r;
  div_vec_t          rem_nxt;
  logic [STEP_W-1:0] bit_idx;
  logic              bit_in;

  // Restoring remainder, one dividend bit per cycle, MSB first, six lanes.
  assign bit_idx = LAST_STEP - step_r;
  assign bit_in  = frame_i[bit_idx];

  always_comb begin
    logic [CNT_W:0] shifted;
    logic [CNT_W:0] dext;
    for (int i = 0; i < NUM_DIV; i++) begin
      shifted = {rem_r[i], bit_in};
      dext    = {1'b0, divs[i]};
      if (shifted >= dext) begin
        rem_nxt[i] = CNT_W'(shifted - dext);
      end else begin
        rem_nxt[i] = CNT_W'(shifted);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign rems      = rem_r;
  assign stat.busy = busy_r || done_r;
  assign stat.done = done_r;

endmodule

/* rtl/core/mrfs_core.sv */
module mrfs_core
  import mrfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  in_item_t         in_data,
  input  cfg_t             cfg,
  input  rem_stat_t        rem_stat,
  input  div_vec_t         rems,
  output logic [CNT_W-1:0] frame_o,
  output out_item_t        result
);

  typedef logic [NUM_AXES-1:0][SUM_W-1:0] axes_t;

  logic [SUM_W-1:0] uptime_r;
  logic [CNT_W-1:0] frame_r;
  div_vec_t         res_r;
  axes_t            run_fa_r, run_fg_r, run_sa_r;
  axes_t            held_fa_r, held_fg_r, held_sa_r;

  logic             run;
  logic [CNT_W:0]   fc_inc;
  logic             wrap;
  logic [CNT_W-1:0] frame_nxt;
  div_vec_t         res_adv;
  logic [NUM_DIV-1:0] beat;
  logic             mag_req;
  axes_t            acc_ext, gyr_ext;
  axes_t            fa_add, fg_add, sa_add;
  axes_t            run_fa_nxt, run_fg_nxt, run_sa_nxt;
  axes_t            held_fa_nxt, held_fg_nxt, held_sa_nxt;
  logic [SUM_W-1:0] uptime_nxt;

  assign run = in_data.system_ready && !in_data.console_busy &&
               !in_data.accel_cal_active && !in_data.esc_cal_active &&
               !in_data.gyro_cal_active && !in_data.mag_cal_active;

  assign uptime_nxt = uptime_r + 1'b1;
  assign fc_inc     = {1'b0, frame_r} + 1'b1;
  assign wrap       = fc_inc > {1'b0, cfg.frame_period};
  assign frame_nxt  = wrap ? CNT_W'(1) : fc_inc[CNT_W-1:0];

  // Each residue tracks frame count modulo its divisor, so a beat is a zero test.
  always_comb begin
    logic [CNT_W-1:0] r_inc;
    logic [CNT_W-1:0] d;
    for (int i = 0; i < NUM_DIV; i++) begin
      d     = cfg.divs[i];
      r_inc = res_r[i] + 1'b1;
      if (wrap) begin
        res_adv[i] = (d == CNT_W'(1)) ? '0 : CNT_W'(1);
      end else begin
        res_adv[i] = (r_inc == d) ? '0 : r_inc;
      end
      beat[i] = (res_adv[i] == '0) && (d != '0);
    end
  end

  assign mag_req = (cfg.divs[DIV_MAG] != '0) &&
                   (res_adv[DIV_MAG] == cfg.divs[DIV_MAG] - 1'b1);

  assign acc_ext[0] = SUM_W'(in_data.accel_x);
  assign acc_ext[1] = SUM_W'(in_data.accel_y);
  assign acc_ext[2] = SUM_W'(in_data.accel_z);
  assign gyr_ext[0] = SUM_W'(in_data.gyro_roll);
  assign gyr_ext[1] = SUM_W'(in_data.gyro_pitch);
  assign gyr_ext[2] = SUM_W'(in_data.gyro_yaw);

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      fa_add[i] = run_fa_r[i] + acc_ext[i];
      fg_add[i] = run_fg_r[i] + gyr_ext[i];
      sa_add[i] = run_sa_r[i] + acc_ext[i];
      run_fa_nxt[i]  = run_fa_r[i];
      run_fg_nxt[i]  = run_fg_r[i];
      run_sa_nxt[i]  = run_sa_r[i];
      held_fa_nxt[i] = held_fa_r[i];
      held_fg_nxt[i] = held_fg_r[i];
      held_sa_nxt[i] = held_sa_r[i];
      if (run) begin
        if (beat[DIV_FAST]) begin
          held_fa_nxt[i] = fa_add[i];
          held_fg_nxt[i] = fg_add[i];
          run_fa_nxt[i]  = '0;
          run_fg_nxt[i]  = '0;
        end else begin
          run_fa_nxt[i] = fa_add[i];
          run_fg_nxt[i] = fg_add[i];
        end
        if (beat[DIV_SLOW]) begin
          held_sa_nxt[i] = sa_add[i];
          run_sa_nxt[i]  = '0;
        end else begin
          run_sa_nxt[i] = sa_add[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uptime_r  <= '0;
      frame_r   <= '0;
      res_r     <= '0;
      run_fa_r  <= '0;
      run_fg_r  <= '0;
      run_sa_r  <= '0;
      held_fa_r <= '0;
      held_fg_r <= '0;
      held_sa_r <= '0;
    end else if (rem_stat.done) begin
      res_r <= rems;
    end else if (accept) begin
      uptime_r  <= uptime_nxt;
      run_fa_r  <= run_fa_nxt;
      run_fg_r  <= run_fg_nxt;
      run_sa_r  <= run_sa_nxt;
      held_fa_r <= held_fa_nxt;
      held_fg_r <= held_fg_nxt;
      held_sa_r <= held_sa_nxt;
      if (run) begin
        frame_r <= frame_nxt;
        res_r   <= res_adv;
      end
    end
  end

  assign frame_o = frame_r;

  assign result.uptime_ms           = uptime_nxt;
  assign result.rate_pulses         = run ? beat : '0;
  assign result.mag_read_request    = run && mag_req;
  assign result.fast_accel_sum_x    = held_fa_nxt[0];
  assign result.fast_accel_sum_y    = held_fa_nxt[1];
  assign result.fast_accel_sum_z    = held_fa_nxt[2];
  assign result.fast_gyro_sum_roll  = held_fg_nxt[0];
  assign result.fast_gyro_sum_pitch = held_fg_nxt[1];
  assign result.fast_gyro_sum_yaw   = held_fg_nxt[2];
  assign result.slow_accel_sum_x    = held_sa_nxt[0];
  assign result.slow_accel_sum_y    = held_sa_nxt[1];
  assign result.slow_accel_sum_z    = held_sa_nxt[2];

endmodule

/* rtl/core/mrfs_outq.sv */
module mrfs_outq
  import mrfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/multi_rate_frame_scheduler_top.sv */
// Multi-rate frame scheduler.
// The input channel (in_valid, in_ready, in_data) takes one tick per transfer:
// gate flags plus accelerometer and gyroscope samples. The result channel
// (out_valid, out_ready, out_data) returns exactly one result per tick: uptime,
// six rate pulses, the magnetometer read request and the held window sums.
// A taken tick's result is formed combinationally and written into the result
// queue that drives out_data. Throughput is one tick per cycle while in_ready
// is high, from counter, residue and adder logic feeding a two-entry queue.
// The queue lets the block keep taking ticks while the receiver stalls; when
// both entries wait, in_ready drops until the receiver takes a result.
// Configuration uses the APB-style port with registers at 4*index. Each
// register write restarts a bit-serial remainder pass that realigns the
// divisor phase counters to the current frame count; in_ready is low during
// the write access, while the pass runs and while its result is loaded.
// Synchronous reset loads the register defaults, clears the counters, sums
// and result queue; no clearing pass follows reset.
module multi_rate_frame_scheduler_top
  import mrfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t             cfg;
  logic             cfg_wr;
  rem_stat_t        rem_stat;
  div_vec_t         rems;
  logic [CNT_W-1:0] frame;
  out_item_t        core_res;
  logic             q_full;
  logic             in_accept;

  assign in_ready  = !q_full && !rem_stat.busy && !cfg_wr;
  assign in_accept = in_valid && in_ready;

  mrfs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  mrfs_remdiv u_remdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_wr),
    .frame_i (frame),
    .divs    (cfg.divs),
    .rems    (rems),
    .stat    (rem_stat)
  );

  mrfs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .in_data  (in_data),
    .cfg      (cfg),
    .rem_stat (rem_stat),
    .rems     (rems),
    .frame_o  (frame),
    .result   (core_res)
  );

  mrfs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (core_res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_realign_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.busy |-> !in_ready)
    else $error("tick transfer allowed while divisor phases realign");

  a_write_starts_realign: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> rem_stat.busy)
    else $error("register write did not start the realign pass");

  a_held_frame_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_data.system_ready) |->
      (core_res.rate_pulses == '0) && !core_res.mag_read_request)
    else $error("pulse raised on a held frame");
`endif

endmodule
